@@ sv/drp_pkg.sv @@
// ----------------------------------------------------------------------------
// drp_pkg: shared types and constants for the rainbow color map
// Widths, fixed-point constants, arctangent table and hue sector codes.
// ----------------------------------------------------------------------------
package drp_pkg;

  // configuration
  localparam int ATAN_STEPS = 16;          // CORDIC iterations, 8..24
  localparam int FRAC_BITS  = 16;          // fraction bits of sample and channels
  localparam int HUE_FRAC   = 16;          // fraction bits of hue in degrees

  // widths
  localparam int SAMPLE_W = 32;
  localparam int CH_W     = FRAC_BITS + 1;
  localparam int XY_W     = SAMPLE_W + 3;  // CORDIC gain headroom
  localparam int Z_W      = HUE_FRAC + 8;  // accumulated angle, signed
  localparam int HS_W     = HUE_FRAC + 11; // hue before wrap, signed
  localparam int HUE_W    = HUE_FRAC + 9;  // wrapped hue, 0 .. 360 deg
  localparam int OFF_W    = HUE_FRAC + 6;  // ramp offset, 0 .. 60 deg
  localparam int P_W      = OFF_W + CH_W;
  localparam int Q_W      = FRAC_BITS + 6; // offset*delta / 2^HUE_FRAC < 60*2^FRAC_BITS
  localparam int RECIP_SH = Q_W + 6;
  localparam int M_W      = RECIP_SH - 5;
  localparam int QM_W     = Q_W + M_W;

  localparam int ONE = 1 << FRAC_BITS;

  // hue landmarks in degrees
  localparam int DEG60  = 60 << HUE_FRAC;
  localparam int DEG120 = 120 << HUE_FRAC;
  localparam int DEG180 = 180 << HUE_FRAC;
  localparam int DEG240 = 240 << HUE_FRAC;
  localparam int DEG300 = 300 << HUE_FRAC;
  localparam int DEG360 = 360 << HUE_FRAC;

  // reciprocal of 60 for floor(q / 60), exact for q < 2^Q_W
  localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SH) + 64'd59) / 64'd60;
  localparam logic [M_W-1:0]  RECIP_M    = M_W'(RECIP_FULL);

  // which channel holds max, which ramps
  typedef enum logic [2:0] {
    SEC_R_MAX_B_RAMP,   // hue above 300
    SEC_R_MAX_G_RAMP,   // hue 0 .. 60
    SEC_G_MAX_R_RAMP,   // hue above 60, below 120
    SEC_G_MAX_B_RAMP,   // hue 120 .. below 180
    SEC_B_MAX_G_RAMP,   // hue 180 .. below 240
    SEC_B_MAX_R_RAMP    // hue 240 .. 300
  } sector_e;

  // atan(2^-i) in degrees, HUE_FRAC fraction bits
  function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:  val = Z_W'(2949120);
      1:  val = Z_W'(1740967);
      2:  val = Z_W'(919879);
      3:  val = Z_W'(466945);
      4:  val = Z_W'(234379);
      5:  val = Z_W'(117304);
      6:  val = Z_W'(58666);
      7:  val = Z_W'(29335);
      8:  val = Z_W'(14668);
      9:  val = Z_W'(7334);
      10: val = Z_W'(3667);
      11: val = Z_W'(1833);
      12: val = Z_W'(917);
      13: val = Z_W'(458);
      14: val = Z_W'(229);
      15: val = Z_W'(115);
      16: val = Z_W'(57);
      17: val = Z_W'(29);
      18: val = Z_W'(14);
      19: val = Z_W'(7);
      20: val = Z_W'(4);
      21: val = Z_W'(2);
      22: val = Z_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ sv/data_to_rainbow_rgb.sv @@
// Pipeline: 16 CORDIC stages, 2 hue/sector stages and 3 ramp stages lie
// between an accepted sample and its pixel, each stage one register.
// Throughput: one sample per cycle; a stall only freezes stages that are full,
// so empty stages keep filling while a finished pixel waits.
// Reset: all stage valids clear, saturation register goes to full (1.0).
// ----------------------------------------------------------------------------
// data_to_rainbow_rgb: rainbow color map
// Signed Q16.16 sample in, RGB pixel out; hue from 180 + 2*atan(sample) deg,
// value |sample| clipped to 1.0, saturation from a config register.
// ----------------------------------------------------------------------------
module data_to_rainbow_rgb (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [drp_pkg::CH_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [drp_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [drp_pkg::CH_W-1:0]     red_o,
  output logic        [drp_pkg::CH_W-1:0]     green_o,
  output logic        [drp_pkg::CH_W-1:0]     blue_o
);
  import drp_pkg::*;

  // saturation register
  logic [CH_W-1:0] sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= CH_W'(ONE);
    end else if (cfg_we_i) begin
      sat_q <= cfg_wdata_i;
    end
  end

  // CORDIC -> hue/sector
  logic                   c_valid, c_stall;
  logic signed [Z_W-1:0]  c_z;
  logic [CH_W-1:0]        c_v;

  drp_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (c_valid),
    .out_stall_i (c_stall),
    .z_o         (c_z),
    .v_o         (c_v)
  );

  // hue/sector -> ramp
  logic             h_valid, h_stall;
  sector_e          h_sec;
  logic [OFF_W-1:0] h_off;
  logic [CH_W-1:0]  h_lo, h_v, h_delta;

  drp_hue u_hue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid),
    .in_stall_o  (c_stall),
    .z_i         (c_z),
    .v_i         (c_v),
    .sat_i       (sat_q),
    .out_valid_o (h_valid),
    .out_stall_i (h_stall),
    .sector_o    (h_sec),
    .offset_o    (h_off),
    .lo_o        (h_lo),
    .v_o         (h_v),
    .delta_o     (h_delta)
  );

  drp_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (h_valid),
    .in_stall_o  (h_stall),
    .sector_i    (h_sec),
    .offset_i    (h_off),
    .lo_i        (h_lo),
    .v_i         (h_v),
    .delta_i     (h_delta),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

@@ sv/drp_cordic.sv @@
// ----------------------------------------------------------------------------
// drp_cordic: pipelined vectoring CORDIC
// One register stage per iteration; also carries the clipped magnitude.
// ----------------------------------------------------------------------------
module drp_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [drp_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [drp_pkg::Z_W-1:0]       z_o,
  output logic        [drp_pkg::CH_W-1:0]      v_o
);
  import drp_pkg::*;

  localparam int LAST = ATAN_STEPS - 1;

  logic signed [XY_W-1:0] x_q [ATAN_STEPS];
  logic signed [XY_W-1:0] y_q [ATAN_STEPS];
  logic signed [Z_W-1:0]  z_q [ATAN_STEPS];
  logic [CH_W-1:0]        v_q [ATAN_STEPS];
  logic [ATAN_STEPS-1:0]  vld_q;
  logic [ATAN_STEPS-1:0]  adv;
  logic [ATAN_STEPS-1:0]  stl;

  // magnitude of the sample, clipped to 1.0
  logic signed [SAMPLE_W:0] ext;
  logic [SAMPLE_W:0]        mag;
  logic [CH_W-1:0]          v_in;

  always_comb begin
    ext  = (SAMPLE_W+1)'(sample_i);
    mag  = ext[SAMPLE_W] ? (SAMPLE_W+1)'(-ext) : (SAMPLE_W+1)'(ext);
    v_in = (mag > (SAMPLE_W+1)'(ONE)) ? CH_W'(ONE) : CH_W'(mag);
  end

  for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_stage
    logic signed [XY_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [Z_W-1:0]  z_in, z_d;
    logic [CH_W-1:0]        v_src;
    logic                   vld_in;

    // stage inputs
    if (i == 0) begin : g_first
      assign x_in   = XY_W'(ONE);
      assign y_in   = XY_W'(sample_i);
      assign z_in   = '0;
      assign v_src  = v_in;
      assign vld_in = in_valid_i;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign v_src  = v_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    // stall chain: a stage holds only when full and blocked downstream
    if (i == LAST) begin : g_tail
      assign stl[i] = out_stall_i;
    end else begin : g_mid
      assign stl[i] = vld_q[i+1] & stl[i+1];
    end
    assign adv[i] = ~vld_q[i] | ~stl[i];

    // rotation toward y = 0; holds once y reaches zero
    always_comb begin
      x_d = x_in;
      y_d = y_in;
      z_d = z_in;
      if (y_in > 0) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + atan_deg(i);
      end else if (y_in < 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - atan_deg(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
        v_q[i] <= v_src;
      end
    end
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = vld_q[LAST];
  assign z_o         = z_q[LAST];
  assign v_o         = v_q[LAST];

endmodule

@@ sv/drp_hue.sv @@
// ----------------------------------------------------------------------------
// drp_hue: hue, delta and sector decode
// Stage 1 wraps the hue and scales value by saturation; stage 2 picks the
// sector, the ramp offset and the channel minimum.
// ----------------------------------------------------------------------------
module drp_hue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [drp_pkg::Z_W-1:0]  z_i,
  input  logic        [drp_pkg::CH_W-1:0] v_i,
  input  logic        [drp_pkg::CH_W-1:0] sat_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output drp_pkg::sector_e                sector_o,
  output logic        [drp_pkg::OFF_W-1:0] offset_o,
  output logic        [drp_pkg::CH_W-1:0] lo_o,
  output logic        [drp_pkg::CH_W-1:0] v_o,
  output logic        [drp_pkg::CH_W-1:0] delta_o
);
  import drp_pkg::*;

  logic [1:0] vld_q, adv, stl;

  // stall chain
  assign stl[1]     = out_stall_i;
  assign stl[0]     = vld_q[1] & stl[1];
  assign adv        = ~vld_q | ~stl;
  assign in_stall_o = ~adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
    end
  end

  // stage 1: hue = 180 + 2z wrapped to 0..360, delta = round(v*s)
  logic signed [HS_W-1:0] hs;
  logic [CH_W-1:0]        s_clip;
  logic [2*CH_W-1:0]      vs;
  logic [HUE_W-1:0]       hue_d, hue_q;
  logic [CH_W-1:0]        delta_d, delta_q, v1_q;

  always_comb begin
    hs = HS_W'(DEG180) + (HS_W'(z_i) <<< 1);
    if (hs < 0) begin
      hs = hs + HS_W'(DEG360);
    end
    if (hs >= HS_W'(DEG360)) begin
      hs = hs - HS_W'(DEG360);
    end
    hue_d   = HUE_W'(hs);
    s_clip  = (sat_i > CH_W'(ONE)) ? CH_W'(ONE) : sat_i;
    vs      = (2*CH_W)'(v_i) * (2*CH_W)'(s_clip) + (2*CH_W)'(ONE >> 1);
    delta_d = CH_W'(vs >> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hue_q   <= hue_d;
      delta_q <= delta_d;
      v1_q    <= v_i;
    end
  end

  // stage 2: sector, ramp offset, minimum
  sector_e          sec_d, sec_q;
  logic [HUE_W-1:0] off_w;
  logic [OFF_W-1:0] off_q;
  logic [CH_W-1:0]  lo_q, v2_q, delta2_q;

  always_comb begin
    if (hue_q > HUE_W'(DEG300)) begin
      sec_d = SEC_R_MAX_B_RAMP;
      off_w = HUE_W'(DEG360) - hue_q;
    end else if (hue_q <= HUE_W'(DEG60)) begin
      sec_d = SEC_R_MAX_G_RAMP;
      off_w = hue_q;
    end else if (hue_q < HUE_W'(DEG120)) begin
      sec_d = SEC_G_MAX_R_RAMP;
      off_w = HUE_W'(DEG120) - hue_q;
    end else if (hue_q < HUE_W'(DEG180)) begin
      sec_d = SEC_G_MAX_B_RAMP;
      off_w = hue_q - HUE_W'(DEG120);
    end else if (hue_q < HUE_W'(DEG240)) begin
      sec_d = SEC_B_MAX_G_RAMP;
      off_w = HUE_W'(DEG240) - hue_q;
    end else begin
      sec_d = SEC_B_MAX_R_RAMP;
      off_w = hue_q - HUE_W'(DEG240);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sec_q    <= sec_d;
      off_q    <= OFF_W'(off_w);
      lo_q     <= v1_q - delta_q;
      v2_q     <= v1_q;
      delta2_q <= delta_q;
    end
  end

  assign out_valid_o = vld_q[1];
  assign sector_o    = sec_q;
  assign offset_o    = off_q;
  assign lo_o        = lo_q;
  assign v_o         = v2_q;
  assign delta_o     = delta2_q;

endmodule

@@ sv/drp_ramp.sv @@
// ----------------------------------------------------------------------------
// drp_ramp: ramp channel and RGB assembly
// ramp = lo + floor(offset * delta / 60 deg), done as a product, a shift
// and a reciprocal multiply by 1/60; last stage is the output register.
// ----------------------------------------------------------------------------
module drp_ramp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  drp_pkg::sector_e                 sector_i,
  input  logic        [drp_pkg::OFF_W-1:0] offset_i,
  input  logic        [drp_pkg::CH_W-1:0]  lo_i,
  input  logic        [drp_pkg::CH_W-1:0]  v_i,
  input  logic        [drp_pkg::CH_W-1:0]  delta_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic        [drp_pkg::CH_W-1:0]  red_o,
  output logic        [drp_pkg::CH_W-1:0]  green_o,
  output logic        [drp_pkg::CH_W-1:0]  blue_o
);
  import drp_pkg::*;

  logic [2:0] vld_q, adv, stl;

  // stall chain
  assign stl[2]     = out_stall_i;
  assign stl[1]     = vld_q[2] & stl[2];
  assign stl[0]     = vld_q[1] & stl[1];
  assign adv        = ~vld_q | ~stl;
  assign in_stall_o = ~adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: offset * delta, drop hue fraction
  logic [P_W-1:0]  prod;
  logic [Q_W-1:0]  q_q;
  sector_e         sec1_q, sec2_q;
  logic [CH_W-1:0] lo1_q, v1_q, lo2_q, v2_q;

  assign prod = P_W'(offset_i) * P_W'(delta_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      q_q    <= Q_W'(prod >> HUE_FRAC);
      sec1_q <= sector_i;
      lo1_q  <= lo_i;
      v1_q   <= v_i;
    end
  end

  // stage 2: multiply by reciprocal of 60
  logic [QM_W-1:0] qm_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      qm_q   <= QM_W'(q_q) * QM_W'(RECIP_M);
      sec2_q <= sec1_q;
      lo2_q  <= lo1_q;
      v2_q   <= v1_q;
    end
  end

  // stage 3: ramp and channel routing into the output register
  logic [CH_W-1:0] rmp;
  logic [CH_W-1:0] r_d, g_d, b_d, r_q, g_q, b_q;

  always_comb begin
    rmp = lo2_q + CH_W'(qm_q >> RECIP_SH);
    case (sec2_q)
      SEC_R_MAX_B_RAMP: begin r_d = v2_q;  g_d = lo2_q; b_d = rmp;   end
      SEC_R_MAX_G_RAMP: begin r_d = v2_q;  g_d = rmp;   b_d = lo2_q; end
      SEC_G_MAX_R_RAMP: begin r_d = rmp;   g_d = v2_q;  b_d = lo2_q; end
      SEC_G_MAX_B_RAMP: begin r_d = lo2_q; g_d = v2_q;  b_d = rmp;   end
      SEC_B_MAX_G_RAMP: begin r_d = lo2_q; g_d = rmp;   b_d = v2_q;  end
      SEC_B_MAX_R_RAMP: begin r_d = rmp;   g_d = lo2_q; b_d = v2_q;  end
      default:          begin r_d = lo2_q; g_d = lo2_q; b_d = v2_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;

endmodule

@@ tb/rainbow_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// rainbow_pixel_checker: pixel predictor and comparator for the color map
// Watches the config write, sample and pixel channels. Each accepted sample
// is turned into an expected pixel. Each accepted pixel is checked, as a
// whole, against the oldest expected one.
// ----------------------------------------------------------------------------
module rainbow_pixel_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [drp_pkg::CH_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [drp_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic        [drp_pkg::CH_W-1:0]     red_i,
  input  logic        [drp_pkg::CH_W-1:0]     green_i,
  input  logic        [drp_pkg::CH_W-1:0]     blue_i,
  output int                                  errors_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import drp_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int TBL_LEN     = 24;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint ARCTAN_DEG [TBL_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    pixel_t                     px;
  } pixel_due_t;

  pixel_due_t      pixels_due [$];
  pixel_due_t      oldest;
  pixel_t          got;
  logic [CH_W-1:0] sat_copy;
  int              err_cnt;

  // Rainbow color of one sample at the given saturation
  function automatic pixel_t rainbow_pixel(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [CH_W-1:0] sat);
    longint x, y, z, nx, ny, hue, one, vv, ss, dl, lo, rr, gg, bb;
    pixel_t px;
    one = longint'(1) << FRAC_BITS;
    x   = one;
    y   = longint'(smp);
    z   = 0;

    // vectoring CORDIC; y stuck at zero leaves x, y and z alone
    for (int i = 0; i < ATAN_STEPS && i < TBL_LEN; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ARCTAN_DEG[i];
        x  = nx;
        y  = ny;
      end else if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ARCTAN_DEG[i];
        x  = nx;
        y  = ny;
      end
    end

    // hue in degrees, wrapped into 0 .. 360
    hue = longint'(DEG180) + 2 * z;
    if (hue < 0) hue = hue + longint'(DEG360);
    if (hue >= longint'(DEG360)) hue = hue - longint'(DEG360);

    // value, clipped saturation, min channel
    vv = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (vv > one) vv = one;
    ss = (longint'(sat) > one) ? one : longint'(sat);
    dl = (vv * ss + (one >> 1)) >>> FRAC_BITS;
    lo = vv - dl;

    // six sectors; ramps are floor(offset * delta / 60 deg)
    if (hue > longint'(DEG300) || hue <= longint'(DEG60)) begin
      rr = vv;
      if (hue > longint'(DEG300)) begin
        gg = lo;
        bb = lo + ((longint'(DEG360) - hue) * dl) / longint'(DEG60);
      end else begin
        bb = lo;
        gg = lo + (hue * dl) / longint'(DEG60);
      end
    end else if (hue < longint'(DEG180)) begin
      gg = vv;
      if (hue < longint'(DEG120)) begin
        bb = lo;
        rr = lo + ((longint'(DEG120) - hue) * dl) / longint'(DEG60);
      end else begin
        rr = lo;
        bb = lo + ((hue - longint'(DEG120)) * dl) / longint'(DEG60);
      end
    end else begin
      bb = vv;
      if (hue < longint'(DEG240)) begin
        rr = lo;
        gg = lo + ((longint'(DEG240) - hue) * dl) / longint'(DEG60);
      end else begin
        gg = lo;
        rr = lo + ((hue - longint'(DEG240)) * dl) / longint'(DEG60);
      end
    end

    px.red   = rr[CH_W-1:0];
    px.green = gg[CH_W-1:0];
    px.blue  = bb[CH_W-1:0];
    return px;
  endfunction

  // Track saturation, queue expected pixels, compare delivered ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_copy = CH_W'(ONE);
      pixels_due.delete();
      err_cnt = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) sat_copy = cfg_wdata_i;

      if (in_valid_i && !in_stall_i) begin
        oldest.sample = sample_i;
        oldest.px     = rainbow_pixel(sample_i, sat_copy);
        pixels_due.push_back(oldest);
      end

      if (out_valid_i && !out_stall_i) begin
        got.red   = red_i;
        got.green = green_i;
        got.blue  = blue_i;
        if (pixels_due.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d",
                     $realtime, red_i, green_i, blue_i);
          err_cnt++;
        end else begin
          oldest = pixels_due.pop_front();
          if (got != oldest.px) begin
            if (err_cnt < MAX_REPORTS)
              $display("%0t: sample %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, oldest.sample, oldest.px.red, oldest.px.green,
                       oldest.px.blue, red_i, green_i, blue_i);
            err_cnt++;
          end
        end
      end

      errors_o  <= err_cnt;
      pending_o <= pixels_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the rainbow color map
// Drives directed and random samples over several saturation settings and
// idling patterns, with two long output hold-offs that back up the pipeline.
// The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drp_pkg::*;

  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int HOLD_LEN        = 80;
  localparam int TAIL_CYCLES     = 40;

  // fixed saturation settings; the last phase picks one at random
  localparam logic [CH_W-1:0] SAT_SETTINGS [NUM_PHASES-1] = '{
    0, 131071, 1, 32768, 65535, 65536, 65537, 16384
  };

  // zero, unit and clip edges, sector boundaries, extremes of the range
  localparam logic signed [SAMPLE_W-1:0] EDGE_SAMPLES [24] = '{
    0, 1, -1, 32768, -32768, 65535, 65536, 65537, -65536, -65537,
    37837, 37838, -37837, -37838, 113511, 113512, -113511, -113512,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 262144, -262144
  };

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CH_W-1:0]            cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [CH_W-1:0]            red;
  logic [CH_W-1:0]            green;
  logic [CH_W-1:0]            blue;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors;
  int pending;

  data_to_rainbow_rgb dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  rainbow_pixel_checker pixel_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .sample_i    (sample),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pixel receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Receiver stalls more first, then sender idles more, then no idling at all
  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        idle_pct = 31;
        stall_pct <= 49;
      end
      1: begin
        idle_pct = 49;
        stall_pct <= 31;
      end
      default: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // One sample request, after an optional random gap with junk on the bus
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      sample   <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected pixel has come out
  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] value;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples at the reset saturation
    set_idling(0);
    foreach (EDGE_SAMPLES[k]) send_sample(EDGE_SAMPLES[k]);
    drain_pixels();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idling(p * 3 / NUM_PHASES);

      // new saturation while the pipeline is empty
      cfg_we    <= 1'b1;
      cfg_wdata <= (p == NUM_PHASES - 1) ? CH_W'($urandom_range(131071)) : SAT_SETTINGS[p];
      @(posedge clk);
      cfg_we <= 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while samples keep coming
        if (n == 30 && (p == 0 || p == 5)) hold_reqs <= hold_reqs + 1;
        case ($urandom_range(3))
          0: value = $urandom;
          1: value = int'($urandom_range(524288)) - 262144;
          2: value = int'($urandom_range(131072)) - 65536;
          default: value = int'($urandom_range(512)) - 256;
        endcase
        send_sample(value);
      end
      drain_pixels();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #400us;
    $display("== FAIL ==");
    $finish;
  end

endmodule
